// ===== rtl/omdc_pkg.sv =====
// Shared types and constants for the orientation match debounce classifier.
package omdc_pkg;

   localparam int NUM_AXES   = 3;
   localparam int AXIS_W     = 16;
   localparam int THRESH_W   = 13;
   localparam int THRESH2_W  = 2 * THRESH_W;
   localparam int SQ_W       = 32;
   localparam int SUM_W      = SQ_W + 2;
   localparam int COUNT_W    = 8;
   localparam int TICKS_W    = 16;
   localparam int REF_W      = NUM_AXES * AXIS_W;
   localparam int CSR_IDX_W  = 3;

   localparam logic [THRESH_W-1:0] THRESH_MIN_EXCL = 13'd40;
   localparam logic [THRESH_W-1:0] THRESH_RESET    = 13'd614;
   localparam logic [COUNT_W-1:0]  CONFIRM_RESET   = 8'd3;
   localparam logic [TICKS_W-1:0]  LOCKOUT_RESET   = 16'd300;

   typedef enum logic [1:0] {
      ORIENT_UNKNOWN = 2'd0,
      ORIENT_OPEN    = 2'd1,
      ORIENT_CLOSED  = 2'd2
   } door_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATCH_THRESHOLD  = 3'd0,
      CSR_CONFIRM_TARGET   = 3'd1,
      CSR_LOCKOUT_TICKS    = 3'd2,
      CSR_OPEN_REFERENCE   = 3'd3,
      CSR_CLOSED_REFERENCE = 3'd4,
      CSR_REFERENCE_VALID  = 3'd5
   } csr_index_type;

   typedef logic [SQ_W-1:0] sq_type;

   // Settings the debounce stage reads.
   typedef struct packed {
      logic [COUNT_W-1:0] confirm_target;
      logic [TICKS_W-1:0] lockout_ticks;
      logic               reference_valid;
   } dbc_cfg_type;

   // Match flags and item kind handed to the debounce stage.
   typedef struct packed {
      logic is_tick;
      logic open_hit;
      logic closed_hit;
   } match_type;

endpackage

// ===== rtl/orientation_match_debounce_classifier.sv =====
// Top level of the door orientation classifier: config registers, pipeline, lanes, merge.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    opcode, accel_x, accel_y, accel_z
//   rsp_     out        rsp_valid/rsp_ready    door_state, commit
//   csr_     in         csr_valid/csr_ready    csr_index (3 b), csr_data (48 b)
//
// One transaction per cycle while responses are taken, through four register stages (input,
// lane squares, merge compare, debounce/result), in that order, to a valid response.
// Debounce state advances only as a transaction enters the result register.
// Each stage loads when it is empty or its successor moves, so a stalled response
// back-pressures requests only once all four stages are full.
// Reset clears valid bits and debounce state and sets config registers to their defaults; csr_ready is always high.
module orientation_match_debounce_classifier (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic signed [omdc_pkg::AXIS_W-1:0]     req_accel_x,
   input  logic signed [omdc_pkg::AXIS_W-1:0]     req_accel_y,
   input  logic signed [omdc_pkg::AXIS_W-1:0]     req_accel_z,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_door_state,
   output logic                                   rsp_commit,
   // configuration channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [omdc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [omdc_pkg::REF_W-1:0]             csr_data
);
   import omdc_pkg::*;

   // configuration registers
   logic [THRESH_W-1:0]  thresh_ff;
   logic [COUNT_W-1:0]   confirm_ff;
   logic [TICKS_W-1:0]   lockout_ff;
   logic [REF_W-1:0]     open_ref_ff;
   logic [REF_W-1:0]     closed_ref_ff;
   logic                 ref_valid_ff;
   logic [THRESH2_W-1:0] thresh_sq_ff, thresh_sq_in;
   logic [THRESH2_W-1:0] thresh_wide;
   logic                 csr_fire;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic en1, en2, en3, en4;
   logic op1_ff, op2_ff;

   // stage 1 payload
   logic signed [AXIS_W-1:0] sample_ff [NUM_AXES];

   sq_type         open_sq [NUM_AXES];
   sq_type         closed_sq [NUM_AXES];
   match_type      match;
   dbc_cfg_type    dbc_cfg;
   door_state_type door_state;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Take register writes; drop thresholds at or below 0.01 g.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= THRESH_RESET;
         confirm_ff    <= CONFIRM_RESET;
         lockout_ff    <= LOCKOUT_RESET;
         open_ref_ff   <= '0;
         closed_ref_ff <= '0;
         ref_valid_ff  <= 1'b0;
      end else if (csr_fire) begin
         case (csr_index_type'(csr_index))
            CSR_MATCH_THRESHOLD: begin
               if (csr_data[THRESH_W-1:0] > THRESH_MIN_EXCL) begin
                  thresh_ff <= csr_data[THRESH_W-1:0];
               end
            end
            CSR_CONFIRM_TARGET:   confirm_ff    <= csr_data[COUNT_W-1:0];
            CSR_LOCKOUT_TICKS:    lockout_ff    <= csr_data[TICKS_W-1:0];
            CSR_OPEN_REFERENCE:   open_ref_ff   <= csr_data;
            CSR_CLOSED_REFERENCE: closed_ref_ff <= csr_data;
            CSR_REFERENCE_VALID:  ref_valid_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Square the threshold once per cycle; it settles long before a sample reaches the merge.
   assign thresh_wide  = {{(THRESH2_W-THRESH_W){1'b0}}, thresh_ff};
   assign thresh_sq_in = thresh_wide * thresh_wide;

   always_ff @(posedge clock) begin
      thresh_sq_ff <= thresh_sq_in;
   end

   // Ready chain: a stage moves when it is empty or its successor moves.
   assign rdy4      = rsp_ready || !v4_ff;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign en1 = req_valid && rdy1;
   assign en2 = v1_ff && rdy2;
   assign en3 = v2_ff && rdy3;
   assign en4 = v3_ff && rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Hold the accepted request.
   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff       <= req_opcode;
         sample_ff[0] <= req_accel_x;
         sample_ff[1] <= req_accel_y;
         sample_ff[2] <= req_accel_z;
      end
      if (en2) begin
         op2_ff <= op1_ff;
      end
   end

   // One lane per axis, each against both references.
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      omdc_lane u_lane (
         .clock        (clock),
         .enable       (en2),
         .sample       (sample_ff[a]),
         .open_axis    (open_ref_ff[a*AXIS_W +: AXIS_W]),
         .closed_axis  (closed_ref_ff[a*AXIS_W +: AXIS_W]),
         .open_sq_ff   (open_sq[a]),
         .closed_sq_ff (closed_sq[a])
      );
   end

   omdc_merge u_merge (
      .clock     (clock),
      .enable    (en3),
      .is_tick   (op2_ff),
      .open_sq   (open_sq),
      .closed_sq (closed_sq),
      .thresh_sq (thresh_sq_ff),
      .match_ff  (match)
   );

   assign dbc_cfg.confirm_target  = confirm_ff;
   assign dbc_cfg.lockout_ticks   = lockout_ff;
   assign dbc_cfg.reference_valid = ref_valid_ff;

   // Advance debounce state as the transaction enters the result register.
   omdc_debounce u_debounce (
      .clock         (clock),
      .reset         (reset),
      .enable        (en4),
      .match         (match),
      .cfg           (dbc_cfg),
      .door_state_ff (door_state),
      .changed_ff    (rsp_commit)
   );

   assign rsp_valid      = v4_ff;
   assign rsp_door_state = door_state;

`ifndef SYNTHESIS
   // A committed change always names a real door state.
   a_changed_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_commit |-> (rsp_door_state != ORIENT_UNKNOWN))
      else $error("state change reported with unknown door state");

   // Without calibration nothing may be committed.
   a_changed_needs_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_commit |-> ref_valid_ff)
      else $error("state change reported without valid calibration");

   // Back-pressure on requests only when the pipeline is full behind a stalled response.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready))
      else $error("request stalled while pipeline has room");
`endif

endmodule

// ===== rtl/omdc_lane.sv =====
// One axis lane: squared differences of a sample axis to both references.
module omdc_lane (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [omdc_pkg::AXIS_W-1:0]  sample,
   input  logic signed [omdc_pkg::AXIS_W-1:0]  open_axis,
   input  logic signed [omdc_pkg::AXIS_W-1:0]  closed_axis,
   output omdc_pkg::sq_type                    open_sq_ff,
   output omdc_pkg::sq_type                    closed_sq_ff
);
   import omdc_pkg::*;

   logic signed [AXIS_W:0]     open_diff;
   logic signed [AXIS_W:0]     closed_diff;
   logic signed [2*AXIS_W+1:0] open_wide;
   logic signed [2*AXIS_W+1:0] closed_wide;
   logic signed [2*AXIS_W+1:0] open_prod;
   logic signed [2*AXIS_W+1:0] closed_prod;
   sq_type                     open_sq_in;
   sq_type                     closed_sq_in;

   // 17-bit differences; squares stay below 2^32
   assign open_diff    = {sample[AXIS_W-1], sample} - {open_axis[AXIS_W-1], open_axis};
   assign closed_diff  = {sample[AXIS_W-1], sample} - {closed_axis[AXIS_W-1], closed_axis};
   assign open_wide    = {{(AXIS_W+1){open_diff[AXIS_W]}}, open_diff};
   assign closed_wide  = {{(AXIS_W+1){closed_diff[AXIS_W]}}, closed_diff};
   assign open_prod    = open_wide * open_wide;
   assign closed_prod  = closed_wide * closed_wide;
   assign open_sq_in   = open_prod[SQ_W-1:0];
   assign closed_sq_in = closed_prod[SQ_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         open_sq_ff   <= open_sq_in;
         closed_sq_ff <= closed_sq_in;
      end
   end

endmodule

// ===== rtl/omdc_merge.sv =====
// Merge stage: sum the lane squares and compare against the squared threshold.
module omdc_merge (
   input  logic                                clock,
   input  logic                                enable,
   input  logic                                is_tick,
   input  omdc_pkg::sq_type                    open_sq [omdc_pkg::NUM_AXES],
   input  omdc_pkg::sq_type                    closed_sq [omdc_pkg::NUM_AXES],
   input  logic [omdc_pkg::THRESH2_W-1:0]      thresh_sq,
   output omdc_pkg::match_type                 match_ff
);
   import omdc_pkg::*;

   logic [SUM_W-1:0] open_sum;
   logic [SUM_W-1:0] closed_sum;
   logic [SUM_W-1:0] thresh_ext;
   match_type        match_in;

   always_comb begin
      open_sum   = '0;
      closed_sum = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         open_sum   = open_sum + {{(SUM_W-SQ_W){1'b0}}, open_sq[i]};
         closed_sum = closed_sum + {{(SUM_W-SQ_W){1'b0}}, closed_sq[i]};
      end
      thresh_ext          = {{(SUM_W-THRESH2_W){1'b0}}, thresh_sq};
      match_in.is_tick    = is_tick;
      match_in.open_hit   = (open_sum < thresh_ext);
      match_in.closed_hit = (closed_sum < thresh_ext);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         match_ff <= match_in;
      end
   end

endmodule

// ===== rtl/omdc_debounce.sv =====
// Debounce and lockout state, plus the result register.
module omdc_debounce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  omdc_pkg::match_type           match,
   input  omdc_pkg::dbc_cfg_type         cfg,
   output omdc_pkg::door_state_type      door_state_ff,
   output logic                          changed_ff
);
   import omdc_pkg::*;

   door_state_type      committed_ff, committed_in;
   door_state_type      cand_ff, cand_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TICKS_W-1:0]  lock_ff, lock_in;
   door_state_type      door_state_in;
   logic                changed_in;
   door_state_type      hit_state;
   logic [COUNT_W-1:0]  count_next;

   always_comb begin
      committed_in = committed_ff;
      cand_in      = cand_ff;
      count_in     = count_ff;
      lock_in      = lock_ff;
      changed_in   = 1'b0;
      count_next   = 8'd1;

      if (match.open_hit) begin
         hit_state = ORIENT_OPEN;
      end else if (match.closed_hit) begin
         hit_state = ORIENT_CLOSED;
      end else begin
         hit_state = ORIENT_UNKNOWN;
      end

      if (match.is_tick) begin
         // time passes even without calibration
         if (lock_ff != '0) begin
            lock_in = lock_ff - 16'd1;
         end
      end else if (cfg.reference_valid && (lock_ff == '0)) begin
         if (hit_state == ORIENT_UNKNOWN) begin
            count_in = '0;
            cand_in  = ORIENT_UNKNOWN;
         end else begin
            if (hit_state == cand_ff) begin
               count_next = count_ff + 8'd1;
            end
            count_in = count_next;
            cand_in  = hit_state;
            if (count_next >= cfg.confirm_target) begin
               if (hit_state != committed_ff) begin
                  committed_in = hit_state;
                  changed_in   = 1'b1;
                  lock_in      = cfg.lockout_ticks;
               end
               count_in = '0;
               cand_in  = ORIENT_UNKNOWN;
            end
         end
      end

      door_state_in = cfg.reference_valid ? committed_in : ORIENT_UNKNOWN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= ORIENT_UNKNOWN;
         cand_ff      <= ORIENT_UNKNOWN;
         count_ff     <= '0;
         lock_ff      <= '0;
      end else if (enable) begin
         committed_ff <= committed_in;
         cand_ff      <= cand_in;
         count_ff     <= count_in;
         lock_ff      <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         door_state_ff <= door_state_in;
         changed_ff    <= changed_in;
      end
   end

endmodule

// ===== sim/door_state_checker.sv =====
// Response checker for the door orientation classifier, with the opcode codes it shares.
package door_tb_pkg;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

endpackage

module door_state_checker
   import omdc_pkg::*;
   import door_tb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_opcode,
   input  logic signed [AXIS_W-1:0]   req_accel_x,
   input  logic signed [AXIS_W-1:0]   req_accel_y,
   input  logic signed [AXIS_W-1:0]   req_accel_z,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_door_state,
   input  logic                       rsp_commit,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [REF_W-1:0]           csr_data,
   output int                         mismatches,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      door_state_type door;
      logic           changed;
   } door_report_type;

   // Register copies.
   logic [THRESH_W-1:0] thresh_cfg;
   logic [COUNT_W-1:0]  confirm_cfg;
   logic [TICKS_W-1:0]  lockout_cfg;
   logic [REF_W-1:0]    open_cfg;
   logic [REF_W-1:0]    closed_cfg;
   logic                calib_ok;

   // Debounce state.
   door_state_type      committed;
   door_state_type      candidate;
   logic [COUNT_W-1:0]  run_length;
   logic [TICKS_W-1:0]  lockout_left;

   door_report_type     expected_reports[$];
   door_report_type     want;
   int                  responses_seen;

   task automatic report_mismatch(input string what);
      $display("%0t ns: response %0d: %s", $time, responses_seen, what);
      mismatches++;
   endtask

   function automatic longint dist_sq(input logic signed [AXIS_W-1:0] ax,
                                      input logic signed [AXIS_W-1:0] ay,
                                      input logic signed [AXIS_W-1:0] az,
                                      input logic [REF_W-1:0] anchor);
      longint dx, dy, dz;
      dx = longint'(ax) - longint'($signed(anchor[15:0]));
      dy = longint'(ay) - longint'($signed(anchor[31:16]));
      dz = longint'(az) - longint'($signed(anchor[47:32]));
      return dx * dx + dy * dy + dz * dz;
   endfunction

   // Advance the debounce state by one transaction and return what it reports.
   function automatic door_report_type classify_item(input opcode_type op,
                                                     input logic signed [AXIS_W-1:0] ax,
                                                     input logic signed [AXIS_W-1:0] ay,
                                                     input logic signed [AXIS_W-1:0] az);
      door_report_type result;
      door_state_type  hit;
      longint          limit_sq;
      result.changed = 1'b0;
      if (op == OP_TICK) begin
         if (lockout_left != 0) lockout_left--;
      end else if (calib_ok && lockout_left == 0) begin
         limit_sq = longint'(thresh_cfg) * longint'(thresh_cfg);
         if (dist_sq(ax, ay, az, open_cfg) < limit_sq) hit = ORIENT_OPEN;
         else if (dist_sq(ax, ay, az, closed_cfg) < limit_sq) hit = ORIENT_CLOSED;
         else hit = ORIENT_UNKNOWN;
         if (hit == ORIENT_UNKNOWN) begin
            run_length = '0;
            candidate  = ORIENT_UNKNOWN;
         end else begin
            if (hit == candidate) begin
               run_length = run_length + 8'd1;
            end else begin
               candidate  = hit;
               run_length = 8'd1;
            end
            if (run_length >= confirm_cfg) begin
               if (hit != committed) begin
                  committed      = hit;
                  result.changed = 1'b1;
                  lockout_left   = lockout_cfg;
               end
               run_length = '0;
               candidate  = ORIENT_UNKNOWN;
            end
         end
      end
      result.door = calib_ok ? committed : ORIENT_UNKNOWN;
      return result;
   endfunction

   always @(posedge clock) begin : watch
      int delta;
      delta = 0;
      if (reset) begin
         thresh_cfg   = THRESH_RESET;
         confirm_cfg  = CONFIRM_RESET;
         lockout_cfg  = LOCKOUT_RESET;
         open_cfg     = '0;
         closed_cfg   = '0;
         calib_ok     = 1'b0;
         committed    = ORIENT_UNKNOWN;
         candidate    = ORIENT_UNKNOWN;
         run_length   = '0;
         lockout_left = '0;
         responses_seen = 0;
         mismatches     = 0;
         expected_reports.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATCH_THRESHOLD: begin
                  if (csr_data[THRESH_W-1:0] > THRESH_MIN_EXCL) begin
                     thresh_cfg = csr_data[THRESH_W-1:0];
                  end
               end
               CSR_CONFIRM_TARGET:   confirm_cfg = csr_data[COUNT_W-1:0];
               CSR_LOCKOUT_TICKS:    lockout_cfg = csr_data[TICKS_W-1:0];
               CSR_OPEN_REFERENCE:   open_cfg    = csr_data;
               CSR_CLOSED_REFERENCE: closed_cfg  = csr_data;
               CSR_REFERENCE_VALID:  calib_ok    = csr_data[0];
               default: ;
            endcase
         end
         // drain first, so a stray response cannot hide behind a fresh request
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch($sformatf("door_state %0d arrived with nothing outstanding",
                                         rsp_door_state));
            end else begin
               want = expected_reports.pop_front();
               delta--;
               if (rsp_door_state !== want.door) begin
                  report_mismatch($sformatf("door_state %0d, predicted %0d",
                                            rsp_door_state, want.door));
               end
               if (rsp_commit !== want.changed) begin
                  report_mismatch($sformatf("commit %0b, predicted %0b",
                                            rsp_commit, want.changed));
               end
            end
            responses_seen++;
         end
         if (req_valid && req_ready) begin
            expected_reports.push_back(classify_item(opcode_type'(req_opcode),
                                                     req_accel_x, req_accel_y, req_accel_z));
            delta++;
         end
         outstanding <= outstanding + delta;
      end
   end

endmodule

// ===== sim/testbench.sv =====
// Top of the classifier testbench: clock, reset, stimulus, flow control and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import omdc_pkg::*;
   import door_tb_pkg::*;

   // Index values past the register list; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int HOLD_CYCLES     = 150;
   localparam int HOLD_BURST      = 30;
   // pipeline is four stages deep; give it a little more before touching registers
   localparam int SETTLE_CYCLES   = 6;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_opcode = 1'b0;
   logic signed [AXIS_W-1:0]  req_accel_x = '0;
   logic signed [AXIS_W-1:0]  req_accel_y = '0;
   logic signed [AXIS_W-1:0]  req_accel_z = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_door_state;
   logic                      rsp_commit;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [REF_W-1:0]          csr_data = '0;
   int                        mismatches;
   int                        outstanding;

   // Flow-control knobs: percent of cycles each side spends idle.
   int                        send_idle_pct = 20;
   int                        recv_idle_pct = 82;
   // Long receiver stall: the stimulus bumps hold_asks, the receiver counts the stall.
   int                        hold_asks = 0;
   int                        hold_taken = 0;
   int                        hold_left = 0;

   // Shadow of the programmed references, used only to aim samples near them.
   int                        stim_thresh = 614;
   logic [REF_W-1:0]          stim_open = '0;
   logic [REF_W-1:0]          stim_closed = '0;
   door_state_type            aim = ORIENT_OPEN;

   orientation_match_debounce_classifier uut (.*);

   door_state_checker door_check (.*);

   always #2 clock = ~clock;

   // Receiver: random back-pressure, or a long hold whenever one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_taken) begin
         rsp_ready  <= 1'b0;
         hold_taken <= hold_asks;
         hold_left  <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [REF_W-1:0] axes_word(input int x, input int y, input int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   // Random offset within plus or minus the current threshold on one axis.
   function automatic int jitter();
      return int'($urandom_range(0, 2 * stim_thresh)) - stim_thresh;
   endfunction

   // Offer one transaction after a random idle gap; hold valid and payload until accepted.
   // Valid drops only when a gap follows, so it never falls and rises in the same step.
   task automatic offer_item(input opcode_type op, input int ax, input int ay, input int az);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_accel_x <= 16'(ax);
      req_accel_y <= 16'(ay);
      req_accel_z <= 16'(az);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic offer_sample(input int ax, input int ay, input int az);
      offer_item(OP_SAMPLE, ax, ay, az);
   endtask

   // Ticks carry junk in the axis fields; the block must ignore it.
   task automatic offer_tick();
      offer_item(OP_TICK, $urandom, $urandom, $urandom);
   endtask

   // Write one register; the caller drops csr_valid after the last write of a batch.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Stop offering, wait until every predicted response is back, then let the pipe settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program every register with a random setting; junk rides in the unused upper bits.
   task automatic load_random_setting();
      logic [REF_W-1:0] noise;
      int               thr;
      noise = 48'({$urandom, $urandom});
      thr = ($urandom_range(7) == 0) ? $urandom_range(0, 8191) : $urandom_range(41, 2500);
      write_reg(CSR_MATCH_THRESHOLD, {noise[REF_W-1:THRESH_W], 13'(thr)});
      if (thr > 40) stim_thresh = thr;
      write_reg(CSR_CONFIRM_TARGET, {noise[REF_W-1:COUNT_W], 8'($urandom_range(0, 4))});
      write_reg(CSR_LOCKOUT_TICKS, {noise[REF_W-1:TICKS_W], 16'($urandom_range(0, 15))});
      stim_open = 48'({$urandom, $urandom});
      // now and then make both references identical, so open must win the tie
      stim_closed = ($urandom_range(4) == 0) ? stim_open : 48'({$urandom, $urandom});
      write_reg(CSR_OPEN_REFERENCE, stim_open);
      write_reg(CSR_CLOSED_REFERENCE, stim_closed);
      write_reg(($urandom_range(1) != 0) ? CSR_SPARE_LO : CSR_SPARE_HI, ~noise);
      write_reg(CSR_REFERENCE_VALID, {noise[REF_W-1:1], 1'($urandom_range(9) != 0)});
      csr_valid <= 1'b0;
   endtask

   // Mostly runs of samples aimed near one reference, so confirmations build up;
   // the rest are ticks and samples anywhere in the field range.
   task automatic offer_random_item();
      int               pick;
      logic [REF_W-1:0] anchor;
      pick = $urandom_range(99);
      if (pick < 28) begin
         offer_tick();
      end else if (pick < 40) begin
         offer_sample($urandom, $urandom, $urandom);
      end else begin
         if ($urandom_range(4) == 0) aim = (aim == ORIENT_OPEN) ? ORIENT_CLOSED : ORIENT_OPEN;
         anchor = (aim == ORIENT_OPEN) ? stim_open : stim_closed;
         offer_sample(anchor[15:0] + jitter(), anchor[31:16] + jitter(),
                      anchor[47:32] + jitter());
      end
   endtask

   initial begin : stimulus
      int phase;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the calibration is not loaded: report unknown.
      offer_sample(32767, -32768, 0);
      drain();

      // Tiny threshold, two-sample confirm, two-tick lockout. The threshold writes of
      // zero and 40 must be dropped; upper junk bits must be masked everywhere.
      write_reg(CSR_MATCH_THRESHOLD, 48'hFFFF_FFFF_E000);
      write_reg(CSR_MATCH_THRESHOLD, {35'h7_FFFF_FFFF, 13'd40});
      write_reg(CSR_MATCH_THRESHOLD, 48'd41);
      write_reg(CSR_CONFIRM_TARGET, 48'hFFFF_FFFF_FF02);
      write_reg(CSR_LOCKOUT_TICKS, 48'hFFFF_FFFF_0002);
      write_reg(CSR_OPEN_REFERENCE, axes_word(0, 0, 4096));
      write_reg(CSR_CLOSED_REFERENCE, axes_word(4096, 0, 0));
      write_reg(CSR_SPARE_LO, 48'({$urandom, $urandom}));
      write_reg(CSR_SPARE_HI, '1);
      write_reg(CSR_REFERENCE_VALID, '1);
      csr_valid <= 1'b0;

      offer_sample(0, 0, 4096);        // open candidate
      offer_sample(0, 0, 0);           // matches nothing: confirmation clears
      offer_sample(0, 0, 4096);
      offer_sample(40, 0, 4096);       // just inside: commit open, lockout starts
      offer_sample(4096, 0, 0);        // dropped during lockout
      offer_tick();
      offer_tick();
      offer_tick();                    // lockout already at zero
      offer_sample(4096, 41, 0);       // exactly on the threshold: no match
      offer_sample(4096, 0, 0);
      offer_sample(4096, 0, -40);      // commit closed
      offer_tick();
      offer_tick();
      offer_sample(0, 0, 4096);        // candidate switches to open...
      offer_sample(4096, 0, 0);        // ...and back to closed
      offer_sample(4096, 0, 0);        // confirms the state already held: no change
      drain();

      // Widest threshold, zero confirm target, both references at the negative corner.
      write_reg(CSR_MATCH_THRESHOLD, 48'd8191);
      write_reg(CSR_CONFIRM_TARGET, 48'd0);
      write_reg(CSR_LOCKOUT_TICKS, 48'd1);
      write_reg(CSR_OPEN_REFERENCE, axes_word(-32768, -32768, -32768));
      write_reg(CSR_CLOSED_REFERENCE, axes_word(-32768, -32768, -32768));
      csr_valid <= 1'b0;
      offer_sample(-32768, -32768, -32768);  // first match commits; open wins the tie
      offer_sample(32767, 32767, 32767);     // dropped during lockout
      drain();

      // Calibration withdrawn: unknown is reported, yet ticks still run the lockout down.
      write_reg(CSR_REFERENCE_VALID, 48'd0);
      csr_valid <= 1'b0;
      offer_tick();
      offer_sample(-32768, -32768, -32768);
      drain();

      write_reg(CSR_REFERENCE_VALID, 48'd1);
      csr_valid <= 1'b0;
      offer_sample(32767, 32767, 32767);     // far from both: committed state reported
      drain();

      // Random phases: sender-light/receiver-heavy idling, then the reverse, then none.
      for (phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct <= 82;
            end
            1: begin
               send_idle_pct = 82;
               recv_idle_pct <= 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         load_random_setting();
         if (phase == 4) begin
            // stall the receiver while a burst keeps coming, so the pipe fills and
            // req_ready has to drop
            hold_asks <= hold_asks + 1;
            repeat (HOLD_BURST) offer_random_item();
         end
         repeat (ITEMS_PER_PHASE) offer_random_item();
         drain();
      end

      // Longest lockout and largest confirm target last, since a long lockout
      // would starve everything after it.
      write_reg(CSR_MATCH_THRESHOLD, 48'd41);
      write_reg(CSR_CONFIRM_TARGET, 48'd1);
      write_reg(CSR_LOCKOUT_TICKS, 48'd65535);
      write_reg(CSR_OPEN_REFERENCE, axes_word(20000, 20000, 20000));
      write_reg(CSR_CLOSED_REFERENCE, axes_word(5, 5, 5));
      write_reg(CSR_REFERENCE_VALID, 48'd1);
      csr_valid <= 1'b0;
      offer_tick();                          // tick down any lockout left by the random phases
      offer_sample(5, 5, 5);
      offer_sample(20000, 20000, 20000);     // one of these two commits a change unless a lockout still runs
      offer_tick();
      drain();
      write_reg(CSR_CONFIRM_TARGET, 48'd255);
      csr_valid <= 1'b0;
      offer_sample(5, 5, 5);
      drain();

      if (mismatches == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
